// ===== rtl/core/dcfe_pkg.sv =====
// Shared types, opcodes and constants for the drive command frame encoder.
// No dependencies; imported by the classifier, queue, serializer and top level.
`timescale 1ns / 1ps
`default_nettype none

package dcfe_pkg;

	// Queue between classifier and serializer
	localparam int QueueDepthDef = 2;

	// Serial interface opcodes and arguments
	localparam logic [7:0] OpDriveWheels = 8'd145;
	localparam logic [7:0] OpDrive       = 8'd137;
	localparam logic [7:0] OpMotors      = 8'd138;
	localparam logic [7:0] BrushOnArg    = 8'd7;
	localparam logic [7:0] BrushOffArg   = 8'd0;

	// Command characters
	localparam logic [7:0] CmdFwd       = 8'h61; // a
	localparam logic [7:0] CmdBack      = 8'h62; // b
	localparam logic [7:0] CmdLeftFwd   = 8'h63; // c
	localparam logic [7:0] CmdRightFwd  = 8'h64; // d
	localparam logic [7:0] CmdLeftBack  = 8'h65; // e
	localparam logic [7:0] CmdRightBack = 8'h66; // f
	localparam logic [7:0] CmdTurnCcw   = 8'h67; // g
	localparam logic [7:0] CmdTurnCw    = 8'h68; // h
	localparam logic [7:0] CmdTune      = 8'h49; // I
	localparam logic [7:0] CmdBrush     = 8'h4A; // J
	localparam logic [7:0] CmdUpperLo   = 8'h41; // A
	localparam logic [7:0] CmdUpperHi   = 8'h48; // H
	localparam logic [7:0] CaseBit      = 8'h20;

	// Speed handling
	localparam logic [7:0] BaseSpeedReset = 8'd100;
	localparam int         SpeedW         = 9;
	localparam int         ProdW          = 17;
	localparam logic [7:0] Div5Mul        = 8'd205;
	localparam int         Div5Shift      = 10;
	localparam logic [15:0] RadiusCcw     = 16'h0001;
	localparam logic [15:0] RadiusCw      = 16'hFFFF;

	// Byte index within a frame
	localparam int             IdxW      = 5;
	localparam logic [IdxW-1:0] WordsLast = 5'd4;
	localparam logic [IdxW-1:0] BrushLast = 5'd1;
	localparam logic [IdxW-1:0] TuneLast  = 5'd16;

	typedef enum logic [1:0] {
		FRAME_WORDS,
		FRAME_BRUSH,
		FRAME_TUNE
	} frame_kind_t;

	// One classified command: frame kind, opcode byte plus two 16-bit words
	typedef struct packed {
		frame_kind_t kind;
		logic [7:0]  head;
		logic [15:0] w0;
		logic [15:0] w1;
	} frame_desc_t;

	function automatic logic [7:0] tune_byte(input logic [IdxW-1:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = 8'd140;
			5'd1:    b = 8'd2;
			5'd2:    b = 8'd6;
			5'd3:    b = 8'd84;
			5'd4:    b = 8'd5;
			5'd5:    b = 8'd91;
			5'd6:    b = 8'd5;
			5'd7:    b = 8'd100;
			5'd8:    b = 8'd5;
			5'd9:    b = 8'd96;
			5'd10:   b = 8'd5;
			5'd11:   b = 8'd98;
			5'd12:   b = 8'd5;
			5'd13:   b = 8'd103;
			5'd14:   b = 8'd5;
			5'd15:   b = 8'd141;
			5'd16:   b = 8'd2;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dcfe_front.sv =====
// Command classifier: holds base speed and brush state, turns each command
// into a frame descriptor. Depends on dcfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcfe_front import dcfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic [7:0]  command,
	input  wire logic        front_clear,
	input  wire logic        front_right_clear,
	input  wire logic        front_left_clear,
	input  wire logic        back_clear,
	input  wire logic        back_right_clear,
	input  wire logic        back_left_clear,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        q_room,
	output logic             q_push,
	output frame_desc_t      q_desc
);

	logic [7:0]        base_speed_q;
	logic              brush_on_q;
	logic              upper;
	logic [7:0]        cmd_lc;
	logic [SpeedW-1:0] speed;
	logic [ProdW-1:0]  prod;
	logic [15:0]       sp, sn, slp, sln;
	frame_desc_t       stop_desc;

	assign in_ready = q_room;
	assign q_push   = in_valid & q_room;

	// Scale speed and derive the slow wheel speed (x/5 as x*205 >> 10)
	always_comb begin
		upper  = (command >= CmdUpperLo) && (command <= CmdUpperHi);
		cmd_lc = upper ? (command | CaseBit) : command;
		speed  = upper ? {base_speed_q, 1'b0} : {1'b0, base_speed_q};
		prod   = ProdW'(speed) * ProdW'(Div5Mul);
		sp     = 16'(speed);
		sn     = 16'(0) - sp;
		slp    = 16'(prod[ProdW-1:Div5Shift]);
		sln    = 16'(0) - slp;
		stop_desc = '{kind: FRAME_WORDS, head: OpDrive, w0: 16'h0000, w1: 16'h0000};
	end

	// Classify the command
	always_comb begin
		q_desc = stop_desc;
		unique case (cmd_lc)
			CmdFwd: begin
				if (front_clear && front_right_clear && front_left_clear)
					q_desc = '{kind: FRAME_WORDS, head: OpDriveWheels, w0: sp, w1: sp};
			end
			CmdBack: begin
				if (back_clear && back_right_clear && back_left_clear)
					q_desc = '{kind: FRAME_WORDS, head: OpDriveWheels, w0: sn, w1: sn};
			end
			CmdLeftFwd: begin
				if (front_clear && front_left_clear)
					q_desc = '{kind: FRAME_WORDS, head: OpDriveWheels, w0: sp, w1: slp};
			end
			CmdRightFwd: begin
				if (front_clear && front_right_clear)
					q_desc = '{kind: FRAME_WORDS, head: OpDriveWheels, w0: slp, w1: sp};
			end
			CmdLeftBack: begin
				if (back_clear && back_left_clear)
					q_desc = '{kind: FRAME_WORDS, head: OpDriveWheels, w0: sn, w1: sln};
			end
			CmdRightBack: begin
				if (back_clear && back_right_clear)
					q_desc = '{kind: FRAME_WORDS, head: OpDriveWheels, w0: sln, w1: sn};
			end
			CmdTurnCcw: begin
				q_desc = '{kind: FRAME_WORDS, head: OpDrive, w0: sp, w1: RadiusCcw};
			end
			CmdTurnCw: begin
				q_desc = '{kind: FRAME_WORDS, head: OpDrive, w0: sp, w1: RadiusCw};
			end
			CmdTune: begin
				q_desc = '{kind: FRAME_TUNE, head: 8'h00, w0: 16'h0000, w1: 16'h0000};
			end
			CmdBrush: begin
				q_desc = '{kind: FRAME_BRUSH, head: OpMotors,
					w0: {8'h00, (brush_on_q ? BrushOffArg : BrushOnArg)}, w1: 16'h0000};
			end
			default: begin
				q_desc = stop_desc;
			end
		endcase
	end

	// Hold configuration and flip brush state on each brush transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q <= BaseSpeedReset;
			brush_on_q   <= 1'b0;
		end else begin
			if (cfg_we)
				base_speed_q <= cfg_data;
			if (q_push && (command == CmdBrush))
				brush_on_q <= ~brush_on_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dcfe_queue.sv =====
// Short descriptor queue between classifier and serializer.
// Depends on dcfe_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module dcfe_queue import dcfe_pkg::*; #(
	parameter int Depth = QueueDepthDef
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  frame_desc_t       push_desc,
	output logic              room,
	input  wire logic         pop,
	output logic              head_valid,
	output frame_desc_t       head_desc
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	frame_desc_t     slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign room       = (count_q != FullCnt);
	assign head_valid = (count_q != '0);
	assign head_desc  = slot_q[rd_ptr_q];

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_desc;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dcfe_back.sv =====
// Frame serializer: walks one descriptor a byte per unstalled cycle into an
// output register. Depends on dcfe_pkg for descriptor type and tune table.
`timescale 1ns / 1ps
`default_nettype none

module dcfe_back import dcfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  frame_desc_t      q_desc,
	output logic             q_pop,
	output logic [7:0]       tx_byte,
	output logic             frame_end,
	output logic             out_valid,
	input  wire logic        out_ready
);

	frame_desc_t     cur_q;
	logic            busy_q;
	logic [IdxW-1:0] idx_q;
	logic            out_valid_q;
	logic [7:0]      tx_byte_q;
	logic            frame_end_q;
	logic [7:0]      byte_now;
	logic            last_now;
	logic            load;

	// Select the current byte of the frame
	always_comb begin
		byte_now = 8'h00;
		last_now = 1'b1;
		unique case (cur_q.kind)
			FRAME_WORDS: begin
				last_now = (idx_q == WordsLast);
				unique case (idx_q)
					5'd0:    byte_now = cur_q.head;
					5'd1:    byte_now = cur_q.w0[15:8];
					5'd2:    byte_now = cur_q.w0[7:0];
					5'd3:    byte_now = cur_q.w1[15:8];
					default: byte_now = cur_q.w1[7:0];
				endcase
			end
			FRAME_BRUSH: begin
				last_now = (idx_q == BrushLast);
				byte_now = (idx_q == '0) ? cur_q.head : cur_q.w0[7:0];
			end
			FRAME_TUNE: begin
				last_now = (idx_q == TuneLast);
				byte_now = tune_byte(idx_q);
			end
			default: begin
				byte_now = 8'h00;
				last_now = 1'b1;
			end
		endcase
	end

	assign load  = busy_q && (!out_valid_q || out_ready);
	assign q_pop = q_valid && (!busy_q || (load && last_now));

	assign tx_byte   = tx_byte_q;
	assign frame_end = frame_end_q;
	assign out_valid = out_valid_q;

	// Control: frame ownership, byte index, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load && last_now) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Payload: descriptor and output byte
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_desc;
		if (load) begin
			tx_byte_q   <= byte_now;
			frame_end_q <= last_now;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/drive_command_frame_encoder.sv =====
// Top level of the drive command frame encoder: classifier, descriptor
// queue and serializer. Depends on dcfe_pkg, dcfe_front, dcfe_queue, dcfe_back.
//
//   Port group   Direction  Handshake            Contents
//   input        in         in_valid/in_ready    command, six *_clear sensor bits
//   output       out        out_valid/out_ready  tx_byte, frame_end
//   config       in         cfg_we (no wait)     cfg_data -> base_speed
//
// Each command yields 5 bytes (drive, stop), 2 bytes (brush) or 17 bytes
// (tune); the serializer emits one byte per cycle unless the output stalls.
// When idle, it loads a command from the queue slot into its descriptor
// register, then the first byte; otherwise it follows the previous frame's last byte.
// A command is taken every cycle while the QueueDepth-entry queue has room.
// Reset clears base_speed to 100, brush off, queue and output empty.
// A stalled output holds its byte; the queue lets input run ahead meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module drive_command_frame_encoder import dcfe_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic [7:0]  command,
	input  wire logic        front_clear,
	input  wire logic        front_right_clear,
	input  wire logic        front_left_clear,
	input  wire logic        back_clear,
	input  wire logic        back_right_clear,
	input  wire logic        back_left_clear,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic [7:0]       tx_byte,
	output logic             frame_end,
	output logic             out_valid,
	input  wire logic        out_ready
);

	logic        q_room;
	logic        q_push;
	frame_desc_t q_push_desc;
	logic        q_pop;
	logic        q_head_valid;
	frame_desc_t q_head_desc;

	dcfe_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.command           (command),
		.front_clear       (front_clear),
		.front_right_clear (front_right_clear),
		.front_left_clear  (front_left_clear),
		.back_clear        (back_clear),
		.back_right_clear  (back_right_clear),
		.back_left_clear   (back_left_clear),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.q_room            (q_room),
		.q_push            (q_push),
		.q_desc            (q_push_desc)
	);

	dcfe_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_push_desc),
		.room       (q_room),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_desc  (q_head_desc)
	);

	dcfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_head_valid),
		.q_desc    (q_head_desc),
		.q_pop     (q_pop),
		.tx_byte   (tx_byte),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

`default_nettype wire

// ===== rtl/core/dcfe_checker.sv =====
// Port-level checks for the drive command frame encoder, bound to the top.
// Depends on drive_command_frame_encoder only through its ports.
`timescale 1ns / 1ps
`default_nettype none

module dcfe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_we,
	input wire logic [7:0] command,
	input wire logic       front_clear,
	input wire logic       front_right_clear,
	input wire logic       front_left_clear,
	input wire logic       back_clear,
	input wire logic       back_right_clear,
	input wire logic       back_left_clear,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] tx_byte,
	input wire logic       frame_end,
	input wire logic       out_valid,
	input wire logic       out_ready
);

	// Output is empty when reset releases
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	// Waiting command keeps its valid and payload until the transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable({command, front_clear,
			front_right_clear, front_left_clear, back_clear, back_right_clear,
			back_left_clear})))
		else $error("input valid or payload changed while waiting");

	// Stalled output keeps its valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output valid dropped while stalled");

	// Stalled output keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(tx_byte) && $stable(frame_end)))
		else $error("output payload changed while stalled");

	// Speed is written only while no transfer is pending on either side
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> (!in_valid && !out_valid))
		else $error("configuration write while a transfer is pending");

endmodule

bind drive_command_frame_encoder dcfe_checker u_dcfe_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for drive_command_frame_encoder: drives commands and sensor bits,
// predicts each serial byte frame and compares every transferred byte against it.
// Depends on dcfe_pkg and the drive_command_frame_encoder RTL.
`timescale 1ns / 1ps

module testbench;
	import dcfe_pkg::*;

	localparam logic [7:0] CmdStop     = 8'h4B; // K
	localparam int         CycleLimit  = 200000;
	localparam int         LongHold    = 300;
	localparam int         SettleTicks = 8;

	// Sensor bit positions within the clear vector
	localparam int SnsFront      = 0;
	localparam int SnsFrontRight = 1;
	localparam int SnsFrontLeft  = 2;
	localparam int SnsBack       = 3;
	localparam int SnsBackRight  = 4;
	localparam int SnsBackLeft   = 5;

	// Tune bytes, first byte in the top position
	localparam logic [17*8-1:0] TuneSeq = {
		8'd140, 8'd2, 8'd6, 8'd84, 8'd5, 8'd91, 8'd5, 8'd100, 8'd5,
		8'd96, 8'd5, 8'd98, 8'd5, 8'd103, 8'd5, 8'd141, 8'd2
	};

	typedef struct packed {
		logic [7:0] command;
		logic [5:0] clear;
		logic       drain_first;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} tx_due_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'd0;
	logic [7:0] command = 8'd0;
	logic       front_clear = 1'b1;
	logic       front_right_clear = 1'b1;
	logic       front_left_clear = 1'b1;
	logic       back_clear = 1'b1;
	logic       back_right_clear = 1'b1;
	logic       back_left_clear = 1'b1;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] tx_byte;
	logic       frame_end;
	logic       out_valid;
	logic       out_ready = 1'b0;

	cmd_item_t pending_cmds[$];
	tx_due_t   frames_due[$];
	cmd_item_t cur_cmd;
	tx_due_t   head_due;
	logic      cmd_held = 1'b0;
	logic [7:0] model_speed = BaseSpeedReset;
	logic      model_brush = 1'b0;
	int        sender_idle_pct = 0;
	int        rx_stall_pct = 0;
	int        holds_asked = 0;
	int        holds_served = 0;
	int        hold_left = 0;
	int        mismatches = 0;
	int        cycle_count = 0;

	drive_command_frame_encoder dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.command           (command),
		.front_clear       (front_clear),
		.front_right_clear (front_right_clear),
		.front_left_clear  (front_left_clear),
		.back_clear        (back_clear),
		.back_right_clear  (back_right_clear),
		.back_left_clear   (back_left_clear),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.tx_byte           (tx_byte),
		.frame_end         (frame_end),
		.out_valid         (out_valid),
		.out_ready         (out_ready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Frame prediction
	function automatic void push_tx(input logic [7:0] b, input logic last);
		tx_due_t d;
		d.data = b;
		d.last = last;
		frames_due.push_back(d);
	endfunction

	function automatic void push_frame(input logic [7:0] head, input logic [15:0] w0,
			input logic [15:0] w1);
		push_tx(head, 1'b0);
		push_tx(w0[15:8], 1'b0);
		push_tx(w0[7:0], 1'b0);
		push_tx(w1[15:8], 1'b0);
		push_tx(w1[7:0], 1'b1);
	endfunction

	function automatic void predict_frame(input cmd_item_t it);
		logic [7:0]  ch;
		logic [15:0] spd;
		logic [15:0] slow;
		logic        f_blk, fr_blk, fl_blk, b_blk, br_blk, bl_blk;
		ch = it.command;
		spd = {8'd0, model_speed};
		f_blk  = !it.clear[SnsFront];
		fr_blk = !it.clear[SnsFrontRight];
		fl_blk = !it.clear[SnsFrontLeft];
		b_blk  = !it.clear[SnsBack];
		br_blk = !it.clear[SnsBackRight];
		bl_blk = !it.clear[SnsBackLeft];
		// uppercase drive and turn letters run at double speed
		if (ch >= CmdUpperLo && ch <= CmdUpperHi) begin
			spd = spd << 1;
			ch = ch | CaseBit;
		end
		slow = spd / 16'd5;
		case (ch)
			CmdFwd: begin
				if (f_blk || fr_blk || fl_blk) push_frame(OpDrive, 16'd0, 16'd0);
				else push_frame(OpDriveWheels, spd, spd);
			end
			CmdBack: begin
				if (b_blk || br_blk || bl_blk) push_frame(OpDrive, 16'd0, 16'd0);
				else push_frame(OpDriveWheels, 16'd0 - spd, 16'd0 - spd);
			end
			CmdLeftFwd: begin
				if (f_blk || fl_blk) push_frame(OpDrive, 16'd0, 16'd0);
				else push_frame(OpDriveWheels, spd, slow);
			end
			CmdRightFwd: begin
				if (f_blk || fr_blk) push_frame(OpDrive, 16'd0, 16'd0);
				else push_frame(OpDriveWheels, slow, spd);
			end
			CmdLeftBack: begin
				if (b_blk || bl_blk) push_frame(OpDrive, 16'd0, 16'd0);
				else push_frame(OpDriveWheels, 16'd0 - spd, 16'd0 - slow);
			end
			CmdRightBack: begin
				if (b_blk || br_blk) push_frame(OpDrive, 16'd0, 16'd0);
				else push_frame(OpDriveWheels, 16'd0 - slow, 16'd0 - spd);
			end
			CmdTurnCcw: push_frame(OpDrive, spd, RadiusCcw);
			CmdTurnCw:  push_frame(OpDrive, spd, RadiusCw);
			CmdTune: begin
				for (int i = 0; i < 17; i++)
					push_tx(TuneSeq[(16 - i) * 8 +: 8], i == 16);
			end
			CmdBrush: begin
				push_tx(OpMotors, 1'b0);
				push_tx(model_brush ? BrushOffArg : BrushOnArg, 1'b1);
				model_brush = !model_brush;
			end
			default: push_frame(OpDrive, 16'd0, 16'd0);
		endcase
	endfunction

	// Stimulus construction
	function automatic cmd_item_t make_cmd(input logic [7:0] c, input logic [5:0] clr);
		cmd_item_t it;
		it.command = c;
		it.clear = clr;
		it.drain_first = 1'b0;
		return it;
	endfunction

	task automatic add_directed();
		// one relevant sensor blocked per drive direction, and forward with only rear ones blocked
		pending_cmds.push_back(make_cmd(CmdFwd, ~(6'd1 << SnsFrontLeft)));
		pending_cmds.push_back(make_cmd(CmdFwd, ~((6'd1 << SnsBack) | (6'd1 << SnsBackLeft))));
		pending_cmds.push_back(make_cmd(CmdBack, ~(6'd1 << SnsBackRight)));
		pending_cmds.push_back(make_cmd(CmdLeftFwd, ~(6'd1 << SnsFront)));
		pending_cmds.push_back(make_cmd(CmdRightFwd, ~(6'd1 << SnsFrontRight)));
		pending_cmds.push_back(make_cmd(CmdLeftBack, ~(6'd1 << SnsBackLeft)));
		pending_cmds.push_back(make_cmd(CmdRightBack, ~(6'd1 << SnsBack)));
		// turns ignore sensors
		pending_cmds.push_back(make_cmd(CmdTurnCcw, 6'd0));
		pending_cmds.push_back(make_cmd(CmdTurnCw, 6'd0));
		// uppercase, everything clear
		for (int i = 0; i < 8; i++)
			pending_cmds.push_back(make_cmd(CmdUpperLo + 8'(i), 6'h3F));
		pending_cmds.push_back(make_cmd(CmdTune, 6'h3F));
		pending_cmds.push_back(make_cmd(CmdBrush, 6'h3F));
		pending_cmds.push_back(make_cmd(CmdBrush, 6'h00));
		pending_cmds.push_back(make_cmd(CmdStop, 6'h3F));
		pending_cmds.push_back(make_cmd(8'h00, 6'h3F));
		pending_cmds.push_back(make_cmd(8'hFF, 6'h00));
	endtask

	task automatic add_random(input int n);
		cmd_item_t it;
		int        r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(24);
			if (r < 8) it.command = CmdFwd + 8'(r);
			else if (r < 16) it.command = CmdUpperLo + 8'(r - 8);
			else if (r == 16) it.command = CmdTune;
			else if (r == 17) it.command = CmdBrush;
			else if (r == 18) it.command = CmdStop;
			else it.command = 8'($urandom);
			for (int k = 0; k < 6; k++)
				it.clear[k] = ($urandom_range(3) != 0);
			// pause the sender once per batch until every byte is out
			it.drain_first = (i == n / 2);
			pending_cmds.push_back(it);
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || cmd_held || frames_due.size() != 0);
		repeat (SettleTicks) @(posedge clk);
	endtask

	task automatic set_speed(input logic [7:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_speed = v;
	endtask

	// Command driver: predict on each transfer, then offer the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd_held = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_frame(cur_cmd);
				cmd_held = 1'b0;
			end
			if (!cmd_held) begin
				if (pending_cmds.size() != 0
						&& !(pending_cmds[0].drain_first && frames_due.size() != 0)
						&& $urandom_range(99) >= sender_idle_pct) begin
					cur_cmd = pending_cmds.pop_front();
					cmd_held = 1'b1;
					command           <= cur_cmd.command;
					front_clear       <= cur_cmd.clear[SnsFront];
					front_right_clear <= cur_cmd.clear[SnsFrontRight];
					front_left_clear  <= cur_cmd.clear[SnsFrontLeft];
					back_clear        <= cur_cmd.clear[SnsBack];
					back_right_clear  <= cur_cmd.clear[SnsBackRight];
					back_left_clear   <= cur_cmd.clear[SnsBackLeft];
					in_valid          <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Byte receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = LongHold;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Byte checker: compare each transfer with the oldest predicted byte
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				$error("unexpected byte: tx_byte %0d frame_end %0d", tx_byte, frame_end);
				mismatches++;
			end else begin
				head_due = frames_due.pop_front();
				if (tx_byte !== head_due.data) begin
					$error("tx_byte mismatch: expected %0d, got %0d", head_due.data, tx_byte);
					mismatches++;
				end
				if (frame_end !== head_due.last) begin
					$error("frame_end mismatch: expected %0d, got %0d", head_due.last, frame_end);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Phase sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset speed, no idling
		sender_idle_pct = 0;
		rx_stall_pct = 0;
		add_directed();
		add_random(50);
		wait_idle();

		// top speed, sparse sender
		set_speed(8'd255);
		sender_idle_pct = 50;
		rx_stall_pct = 0;
		add_random(55);
		wait_idle();

		// zero speed, stalling receiver
		set_speed(8'd0);
		sender_idle_pct = 0;
		rx_stall_pct = 50;
		add_random(55);
		wait_idle();

		// nominal maximum, both sides idle
		set_speed(8'd250);
		sender_idle_pct = 32;
		rx_stall_pct = 32;
		add_random(55);
		wait_idle();

		// random speed, long receiver hold-off while the sender keeps offering
		set_speed(8'($urandom_range(255)));
		sender_idle_pct = 0;
		rx_stall_pct = 0;
		holds_asked++;
		add_random(55);
		wait_idle();

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
